[src/vsa_pkg.sv]
`default_nettype none
package vsa_pkg;

  // default sizes
  localparam int unsigned NumEntriesDef  = 256;
  localparam int unsigned HistDepthDef   = 16;
  localparam int unsigned VersionBitsDef = 16;

  // request codes
  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_SNAP = 2'd1;
  localparam logic [1:0] REQ_GET  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_INDEX = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_TAKEN = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  // configuration register indexes
  localparam logic REG_ACTIVE_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    EM_ZERO,
    EM_SNAP,
    EM_ENTRY,
    EM_SEARCH
  } emit_sel_e;

  typedef struct packed {
    logic      clear_en;
    logic      capture;
    logic      rd_last;
    logic      search_init;
    logic      search_step;
    logic      wr_append;
    logic      wr_overwrite;
    logic      snap_adv;
    logic      emit;
    emit_sel_e emit_sel;
    logic [2:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_set;
    logic is_snap;
    logic is_get;
    logic idx_bad;
    logic cnt_zero;
    logic snap_taken;
    logic exhausted;
    logic ver_match;
    logic hist_full;
    logic search_more;
  } stat_t;

endpackage
`default_nettype wire

[src/vsa_ctrl.sv]
`default_nettype none
module vsa_ctrl import vsa_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CNT    = 3'd2;
  localparam logic [2:0] S_SETCHK = 3'd3;
  localparam logic [2:0] S_LAST   = 3'd4;
  localparam logic [2:0] S_PROBE  = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_sel    = EM_ZERO;
    cmd_o.emit_status = ST_OK;
    state_d           = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CNT;
        end
      end
      S_CNT: begin
        state_d = S_IDLE;
        if (stat_i.is_snap) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_sel    = EM_SNAP;
          cmd_o.emit_status = stat_i.exhausted ? ST_EXHAUSTED : ST_OK;
          cmd_o.snap_adv    = !stat_i.exhausted;
        end else if ((stat_i.is_set || stat_i.is_get) && stat_i.idx_bad) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_BAD_INDEX;
        end else if (stat_i.is_set) begin
          if (stat_i.cnt_zero) begin
            cmd_o.wr_append = 1'b1;
            cmd_o.emit      = 1'b1;
          end else begin
            cmd_o.rd_last = 1'b1;
            state_d       = S_SETCHK;
          end
        end else if (stat_i.is_get) begin
          if (!stat_i.snap_taken) begin
            if (stat_i.cnt_zero) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = ST_NOT_TAKEN;
            end else begin
              cmd_o.rd_last = 1'b1;
              state_d       = S_LAST;
            end
          end else if (stat_i.cnt_zero) begin
            cmd_o.emit = 1'b1;
          end else begin
            cmd_o.search_init = 1'b1;
            state_d           = S_PROBE;
          end
        end else begin
          cmd_o.emit = 1'b1;
        end
      end
      S_SETCHK: begin
        state_d    = S_IDLE;
        cmd_o.emit = 1'b1;
        if (stat_i.ver_match) begin
          cmd_o.wr_overwrite = 1'b1;
        end else if (stat_i.hist_full) begin
          cmd_o.emit_status = ST_FULL;
        end else begin
          cmd_o.wr_append = 1'b1;
        end
      end
      S_LAST: begin
        state_d           = S_IDLE;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_sel    = EM_ENTRY;
        cmd_o.emit_status = ST_NOT_TAKEN;
      end
      S_PROBE: begin
        cmd_o.search_step = 1'b1;
        if (!stat_i.search_more) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EM_SEARCH;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/vsa_datapath.sv]
`default_nettype none
module vsa_datapath import vsa_pkg::*; #(
  parameter int unsigned NUM_ENTRIES  = NumEntriesDef,
  parameter int unsigned HIST_DEPTH   = HistDepthDef,
  parameter int unsigned VERSION_BITS = VersionBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output stat_t                   stat_o,
  input  wire logic [8:0]         active_len_i,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [7:0]         index_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [15:0]        snap_id_i,
  output logic                    done_o,
  output logic signed [31:0]      data_o,
  output logic [2:0]              status_o
);

  localparam int unsigned IDXW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned PW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(HIST_DEPTH + 1);
  localparam int unsigned VB   = VERSION_BITS;
  localparam int unsigned EW   = VB + 32;
  localparam int unsigned MEM_DEPTH = 2 ** (IDXW + PW);
  localparam int unsigned CNT_DEPTH = 2 ** IDXW;

  logic [EW-1:0]   hist_mem [MEM_DEPTH];
  logic [CW-1:0]   cnt_mem  [CNT_DEPTH];

  logic [1:0]         req_q;
  logic [7:0]         idx_q;
  logic [31:0]        val_q;
  logic [15:0]        sid_q;
  logic [CW-1:0]      cnt_q;
  logic [EW-1:0]      ent_q;
  logic [VB-1:0]      ver_q;
  logic [IDXW-1:0]    clr_q;
  logic [CW-1:0]      lo_q, hi_q, mid_q;
  logic [31:0]        res_q;
  logic               done_q;
  logic [31:0]        data_q;
  logic [2:0]         status_q;

  logic [IDXW-1:0]    idx_w;
  logic [PW-1:0]      last_pos;
  logic [VB-1:0]      ent_ver;
  logic [31:0]        ent_val;
  logic               probe_le;
  logic [CW-1:0]      lo_n, hi_n, mid_n;
  logic [CW:0]        mid_sum;
  logic [31:0]        res_n;
  logic               rd_en;
  logic [PW-1:0]      rd_pos;
  logic               wr_en;
  logic [PW-1:0]      wr_pos;
  logic               cnt_we;
  logic [IDXW-1:0]    cnt_waddr;
  logic [CW-1:0]      cnt_wdata;
  logic [31:0]        data_d;

  assign idx_w    = IDXW'(idx_q);
  assign last_pos = PW'(cnt_q - CW'(1));
  assign ent_ver  = ent_q[EW-1:32];
  assign ent_val  = ent_q[31:0];

  // binary search step over the sorted history of one index
  assign probe_le = (32'(ent_ver) <= 32'(sid_q));
  assign lo_n     = probe_le ? (mid_q + CW'(1)) : lo_q;
  assign hi_n     = probe_le ? hi_q : mid_q;
  assign mid_sum  = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n    = mid_sum[CW:1];
  assign res_n    = probe_le ? ent_val : res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      idx_q <= index_i;
      val_q <= value_i;
      sid_q <= snap_id_i;
      cnt_q <= cnt_mem[IDXW'(index_i)];
    end
    if (cmd_i.search_init) begin
      lo_q  <= '0;
      hi_q  <= cnt_q;
      mid_q <= cnt_q >> 1;
      res_q <= '0;
    end else if (cmd_i.search_step) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
      res_q <= res_n;
    end
  end

  // history table port
  always_comb begin
    rd_en  = cmd_i.rd_last || cmd_i.search_init || cmd_i.search_step;
    rd_pos = last_pos;
    if (cmd_i.search_init) begin
      rd_pos = PW'(cnt_q >> 1);
    end else if (cmd_i.search_step) begin
      rd_pos = PW'(mid_n);
    end
    wr_en  = cmd_i.wr_append || cmd_i.wr_overwrite;
    wr_pos = cmd_i.wr_overwrite ? last_pos : PW'(cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[{idx_w, wr_pos}] <= {ver_q, val_q};
    end
    if (rd_en) begin
      ent_q <= hist_mem[{idx_w, rd_pos}];
    end
  end

  // history count table, cleared by a sweep after reset
  assign cnt_we    = cmd_i.clear_en || cmd_i.wr_append;
  assign cnt_waddr = cmd_i.clear_en ? clr_q : idx_w;
  assign cnt_wdata = cmd_i.clear_en ? '0 : (cnt_q + CW'(1));

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      ver_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_q <= clr_q + IDXW'(1);
      end
      if (cmd_i.snap_adv) begin
        ver_q <= ver_q + VB'(1);
      end
      done_q <= cmd_i.emit;
    end
  end

  always_comb begin
    case (cmd_i.emit_sel)
      EM_SNAP:   data_d = 32'(ver_q);
      EM_ENTRY:  data_d = ent_val;
      EM_SEARCH: data_d = res_n;
      default:   data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      data_q   <= data_d;
      status_q <= cmd_i.emit_status;
    end
  end

  always_comb begin
    stat_o.clear_last  = (32'(clr_q) == NUM_ENTRIES - 1);
    stat_o.is_set      = (req_q == REQ_SET);
    stat_o.is_snap     = (req_q == REQ_SNAP);
    stat_o.is_get      = (req_q == REQ_GET);
    stat_o.idx_bad     = !(({1'b0, idx_q} < active_len_i) && (32'(idx_q) < NUM_ENTRIES));
    stat_o.cnt_zero    = (cnt_q == '0);
    stat_o.snap_taken  = (32'(sid_q) < 32'(ver_q));
    stat_o.exhausted   = (ver_q == '1);
    stat_o.ver_match   = (ent_ver == ver_q);
    stat_o.hist_full   = (32'(cnt_q) >= HIST_DEPTH);
    stat_o.search_more = (lo_n < hi_n);
  end

  assign done_o   = done_q;
  assign data_o   = data_q;
  assign status_o = status_q;

endmodule
`default_nettype wire

[src/versioned_snapshot_array.sv]
// sequencing: snap, unknown requests, bad index and any request on an empty history are
//   answered from the decode state; other sets and not-yet-taken gets first read the last
//   history entry; other gets run a binary search over the history of the index
// no new word is taken before the last one is answered; the next word is taken while the result
//   is on the ports; the binary search walks the single read port of the history memory
// reset: asynchronous, active low; a sweep over all NUM_ENTRIES indexes then clears the history
//   counts with busy high; results cannot be stalled by the receiver
`default_nettype none
module versioned_snapshot_array import vsa_pkg::*; #(
  parameter int unsigned NUM_ENTRIES  = NumEntriesDef,
  parameter int unsigned HIST_DEPTH   = HistDepthDef,
  parameter int unsigned VERSION_BITS = VersionBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // apb configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // request word
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [7:0]         index_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [15:0]        snap_id_i,
  // result word, one cycle strobe
  output logic                    done_o,
  output logic signed [31:0]      data_o,
  output logic [2:0]              status_o
);

  cmd_t       cmd;
  stat_t      stat;
  logic [8:0] active_len_q;
  logic       reg_sel;

  // register index is the word address
  assign reg_sel = (paddr[2] == REG_ACTIVE_LENGTH);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(active_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_len_q <= 9'd256;
    end else if (psel && penable && pwrite && reg_sel) begin
      active_len_q <= pwdata[8:0];
    end
  end

  // controller: decodes the request and sequences the memory accesses
  vsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // datapath: history tables, counts, version counter and result register
  vsa_datapath #(
    .NUM_ENTRIES  (NUM_ENTRIES),
    .HIST_DEPTH   (HIST_DEPTH),
    .VERSION_BITS (VERSION_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .active_len_i (active_len_q),
    .req_type_i   (req_type_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .snap_id_i    (snap_id_i),
    .done_o       (done_o),
    .data_o       (data_o),
    .status_o     (status_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without work in progress");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results back to back");

  a_bad_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_BAD_INDEX) |-> (data_o == 32'sd0))
    else $error("bad index result carries data");
`endif

endmodule
`default_nettype wire

[bench/tb_versioned_snapshot_array.sv]
`default_nettype none
module tb_versioned_snapshot_array;
  import vsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NENT  = NumEntriesDef;
  localparam int unsigned HDEP  = HistDepthDef;
  localparam int unsigned VMAX  = (1 << VersionBitsDef) - 1;
  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type_i = REQ_SET;
  logic [7:0]         index_i = '0;
  logic signed [31:0] value_i = '0;
  logic [15:0]        snap_id_i = '0;
  logic               done_o;
  logic signed [31:0] data_o;
  logic [2:0]         status_o;

  versioned_snapshot_array uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .req_type_i, .index_i, .value_i, .snap_id_i,
    .done_o, .data_o, .status_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state: per-index history tables, version counter, active length
  logic [15:0] hist_ver [NENT][HDEP];
  logic [31:0] hist_val [NENT][HDEP];
  int unsigned hist_cnt [NENT];
  logic [15:0] cur_version;
  logic [8:0]  act_len;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  status;
  } answer_t;

  answer_t     expected_answers [$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 38;

  // work out the answer to one request and update the shadow tables
  function automatic answer_t predict_answer(logic [1:0] req, logic [7:0] idx,
                                             logic [31:0] val, logic [15:0] sid);
    answer_t a;
    int unsigned n;
    bit ok;
    a = '0;
    ok = (idx < act_len) && (idx < NENT);
    n = ok ? hist_cnt[idx] : 0;
    case (req)
      REQ_SNAP: begin
        a.data = {16'd0, cur_version};
        if (cur_version >= VMAX) a.status = ST_EXHAUSTED;
        else cur_version = cur_version + 16'd1;
      end
      REQ_SET: begin
        if (!ok) a.status = ST_BAD_INDEX;
        else if (n > 0 && hist_ver[idx][n-1] == cur_version) hist_val[idx][n-1] = val;
        else if (n >= HDEP) a.status = ST_FULL;
        else begin
          hist_ver[idx][n] = cur_version;
          hist_val[idx][n] = val;
          hist_cnt[idx] = n + 1;
        end
      end
      REQ_GET: begin
        if (!ok) a.status = ST_BAD_INDEX;
        else if (sid >= cur_version) begin
          a.status = ST_NOT_TAKEN;
          if (n > 0) a.data = hist_val[idx][n-1];
        end else begin
          // newest entry at or below the asked version
          for (int k = int'(n) - 1; k >= 0; k--) begin
            if (hist_ver[idx][k] <= sid) begin
              a.data = hist_val[idx][k];
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // result checker: one strobe, one word
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word data=%h status=%0d", data_o, status_o);
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (data_o !== e.data || status_o !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: data exp %h got %h, status exp %0d got %0d",
                     e.data, data_o, e.status, status_o);
        end
      end
    end
  end

  // start stays high between back-to-back words; it drops only for idle cycles
  task automatic send_word(logic [1:0] req, logic [7:0] idx, logic [31:0] val,
                           logic [15:0] sid);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= req;
    index_i    <= idx;
    value_i    <= val;
    snap_id_i  <= sid;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_answers.push_back(predict_answer(req, idx, val, sid));
  endtask

  // drain outstanding words, then give the block time to settle
  task automatic wait_quiet();
    start <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_active_length(logic [31:0] v);
    wait_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ACTIVE_LENGTH, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    act_len = v[8:0];
  endtask

  function automatic logic [7:0] pick_index();
    // mostly a handful of indexes so histories fill up
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      1: return 8'(act_len - 9'd1);
      2: return 8'(act_len);
      default: return 8'($urandom_range(7));
    endcase
  endfunction

  // extremes of every field, each operation, the ok, not-taken and full statuses
  task automatic test_directed();
    send_word(REQ_GET, 8'd0, 32'd0, 16'd0);                // empty, not taken
    send_word(REQ_SET, 8'd0, 32'h8000_0000, 16'hffff);
    send_word(REQ_SET, 8'd0, 32'h7fff_ffff, 16'd0);        // overwrite same version
    send_word(REQ_SET, 8'd255, 32'hffff_ffff, 16'd0);
    send_word(REQ_SNAP, 8'd0, 32'd0, 16'd0);
    send_word(REQ_SET, 8'd0, 32'h1234_5678, 16'd0);        // append
    send_word(REQ_GET, 8'd0, 32'd0, 16'd0);                // old snapshot
    send_word(REQ_GET, 8'd255, 32'd0, 16'hffff);
    send_word(REQ_GET, 8'd9, 32'd0, 16'd0);                // no entry, snapshot taken
    send_word(REQ_UNKNOWN, 8'hff, 32'hffff_ffff, 16'hffff);
    // fill one history
    for (int k = 0; k < HDEP; k++) begin
      send_word(REQ_SET, 8'd3, 32'(k), 16'd0);
      send_word(REQ_SNAP, 8'd0, 32'd0, 16'd0);
    end
    send_word(REQ_SET, 8'd3, 32'hdead_beef, 16'd0);        // history full
    send_word(REQ_GET, 8'd3, 32'd0, 16'd5);
    wait_quiet();
  endtask

  task automatic test_lengths();
    write_active_length(32'd0);                            // rejects all
    send_word(REQ_SET, 8'd0, 32'd1, 16'd0);
    send_word(REQ_GET, 8'd0, 32'd0, 16'd0);
    write_active_length(32'd1);
    send_word(REQ_SET, 8'd1, 32'd1, 16'd0);
    send_word(REQ_GET, 8'd0, 32'd0, 16'd1);
    write_active_length(32'hffff_fe05);                    // low nine bits only
    send_word(REQ_GET, 8'd5, 32'd0, 16'd2);
    write_active_length(32'd511);                          // above the array size
    send_word(REQ_SET, 8'd255, 32'd7, 16'd0);
    write_active_length(32'd256);
  endtask

  task automatic test_random(int unsigned count);
    logic [1:0] r;
    for (int unsigned i = 0; i < count; i++) begin
      // a long stretch in the middle with no random gaps, broken only by an active-length write
      idle_pct = (i >= count / 3 && i < count / 2) ? 0 : 38;
      if (i % 150 == 149) write_active_length($urandom_range(1, 256));
      case ($urandom_range(19))
        0, 1, 2, 3:  r = REQ_SNAP;
        4:           r = REQ_UNKNOWN;
        5, 6, 7, 8, 9, 10, 11: r = REQ_SET;
        default:     r = REQ_GET;
      endcase
      send_word(r, pick_index(), $urandom(),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(cur_version + 2)));
    end
    idle_pct = 38;
  endtask

  initial begin
    for (int i = 0; i < NENT; i++) hist_cnt[i] = 0;
    cur_version = '0;
    act_len = 9'd256;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_lengths();
    test_random(700);
    wait_quiet();
    if (mismatches == 0 && expected_answers.size() == 0)
      $display("tb_versioned_snapshot_array: done, clean");
    else
      $display("tb_versioned_snapshot_array: done, errors");
    $finish;
  end

  // watchdog: far beyond the reset sweep plus every word at its longest search
  initial begin
    #20ms;
    $display("tb_versioned_snapshot_array: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
